### rtl/ssr_pkg.sv
// Shared types, constants and helpers for the streaming substring replace block.
package ssr_pkg;

   localparam int MAX_PATTERN = 8;
   localparam int MAX_REPLACE = 8;
   localparam int CHAR_BITS   = 8;
   localparam int WORD_BITS   = 64;
   localparam int LEN_BITS    = 4;
   localparam int IDX_BITS    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CSR_IDX_BITS = 2;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_WORD = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LEN  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REPLACE_WORD = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REPLACE_LEN  = 2'd3;

   localparam logic [LEN_BITS-1:0] MAX_PATTERN_LEN = LEN_BITS'(MAX_PATTERN);
   localparam logic [LEN_BITS-1:0] MAX_REPLACE_LEN = LEN_BITS'(MAX_REPLACE);

   typedef logic [CHAR_BITS-1:0] char_type;
   typedef logic [LEN_BITS-1:0]  len_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       run_last;
      logic       string_end;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic shift_emit;
      logic repl_start;
      logic repl_emit;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic plen_zero;
      logic fill_zero;
      logic prefix_ok;
      logic full_match;
      logic repl_done;
      logic end_flag;
      logic can_emit;
      logic out_free;
   } status_type;

   // Character idx of a packed word; positions past the word read as zero
   function automatic char_type pack_char(input logic [WORD_BITS-1:0] word,
                                          input len_type idx);
      logic [WORD_BITS-1:0] shifted;
      shifted = word >> (32'(idx) * CHAR_BITS);
      return shifted[CHAR_BITS-1:0];
   endfunction

   // Limit a length to its bound
   function automatic len_type clamp_len(input len_type v, input len_type lim);
      return (v > lim) ? lim : v;
   endfunction

endpackage

### rtl/ssr_datapath.sv
// Datapath: configuration registers, match buffer, pending result and output register.
module ssr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ssr_pkg::cmd_type                    cmd,
   input  ssr_pkg::req_type                    req_data,
   input  logic                                csr_wr_en,
   input  logic [ssr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ssr_pkg::WORD_BITS-1:0]       csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output ssr_pkg::rsp_type                    rsp_data,
   output ssr_pkg::status_type                 status
);
   import ssr_pkg::*;

   logic [WORD_BITS-1:0] pattern_word_ff;
   len_type              pattern_len_ff;
   logic [WORD_BITS-1:0] replace_word_ff;
   len_type              replace_len_ff;

   char_type buf_ff [MAX_PATTERN];
   len_type  fill_ff, fill_in;
   logic     end_ff;
   logic     pend_valid_ff, pend_valid_in;
   char_type pend_char_ff, pend_char_in;
   len_type  rep_idx_ff, rep_idx_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;

   len_type  plen, rlen, fill_eff;
   char_type emit_char;
   logic     emit, push, prefix_ok, out_free;
   rsp_type  push_data;

   // Effective lengths and the clamped buffer fill
   always_comb begin
      plen = clamp_len(pattern_len_ff, MAX_PATTERN_LEN);
      rlen = clamp_len(replace_len_ff, MAX_REPLACE_LEN);
      if (plen == '0) begin
         fill_eff = '0;
      end else if (fill_ff >= plen) begin
         fill_eff = plen - len_type'(1);
      end else begin
         fill_eff = fill_ff;
      end
   end

   // Compare the buffered characters with the pattern head, all lanes at once
   always_comb begin
      prefix_ok = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((LEN_BITS'(i) < fill_ff) &&
             (buf_ff[i] != pack_char(pattern_word_ff, LEN_BITS'(i)))) begin
            prefix_ok = 1'b0;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Produce a character (the previous pending one moves to the output register) or finish the run
   always_comb begin
      emit      = cmd.shift_emit || cmd.repl_emit;
      emit_char = cmd.repl_emit ? pack_char(replace_word_ff, rep_idx_ff) : buf_ff[0];
      push      = 1'b0;
      push_data = '0;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      if (emit) begin
         push      = pend_valid_ff;
         push_data = '{out_char: 8'(pend_char_ff), char_valid: 1'b1,
                       run_last: 1'b0, string_end: 1'b0};
         pend_valid_in = 1'b1;
         pend_char_in  = emit_char;
      end else if (cmd.finish) begin
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            push      = 1'b1;
            push_data = '{out_char: 8'(pend_char_ff), char_valid: 1'b1,
                          run_last: 1'b1, string_end: end_ff};
         end else if (end_ff) begin
            push      = 1'b1;
            push_data = '{out_char: 8'd0, char_valid: 1'b0,
                          run_last: 1'b1, string_end: 1'b1};
         end
      end
   end

   // Output register: load on push, drop when taken
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_in       = push_data;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Next fill count and replacement index
   always_comb begin
      fill_in    = fill_ff;
      rep_idx_in = rep_idx_ff;
      if (csr_wr_en && (csr_index == CSR_PATTERN_WORD || csr_index == CSR_PATTERN_LEN)) begin
         fill_in = '0;
      end else if (cmd.load) begin
         fill_in = fill_eff + len_type'(1);
      end else if (cmd.shift_emit) begin
         fill_in = fill_ff - len_type'(1);
      end else if (cmd.repl_start || (cmd.finish && end_ff)) begin
         fill_in = '0;
      end
      if (cmd.repl_start) begin
         rep_idx_in = '0;
      end else if (cmd.repl_emit) begin
         rep_idx_in = rep_idx_ff + len_type'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff         <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pattern_word_ff <= '0;
         pattern_len_ff  <= '0;
         replace_word_ff <= '0;
         replace_len_ff  <= '0;
      end else begin
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PATTERN_WORD: pattern_word_ff <= csr_wdata;
               CSR_PATTERN_LEN:  pattern_len_ff  <= csr_wdata[LEN_BITS-1:0];
               CSR_REPLACE_WORD: replace_word_ff <= csr_wdata;
               CSR_REPLACE_LEN:  replace_len_ff  <= csr_wdata[LEN_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_char_ff <= pend_char_in;
      rep_idx_ff   <= rep_idx_in;
      rsp_ff       <= rsp_in;
      if (cmd.load) begin
         end_ff <= req_data.in_end;
         buf_ff[fill_eff[IDX_BITS-1:0]] <= CHAR_BITS'(req_data.in_char);
      end else if (cmd.shift_emit) begin
         for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign status = '{plen_zero:  (plen == '0),
                     fill_zero:  (fill_ff == '0),
                     prefix_ok:  prefix_ok,
                     full_match: prefix_ok && (fill_ff == plen),
                     repl_done:  (rep_idx_ff >= rlen),
                     end_flag:   end_ff,
                     can_emit:   !pend_valid_ff || out_free,
                     out_free:   out_free};

endmodule

### rtl/ssr_ctrl.sv
// Controller state machine: sequences load, rescan, replacement, flush and finish.
module ssr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ssr_pkg::status_type  status,
   output ssr_pkg::cmd_type     cmd
);
   import ssr_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_REPL   = 3'd2;
   localparam logic [2:0] ST_FLUSH  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.plen_zero ? ST_FLUSH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.fill_zero) begin
               state_in = ST_FINISH;
            end else if (status.full_match) begin
               cmd.repl_start = 1'b1;
               state_in = ST_REPL;
            end else if (status.prefix_ok) begin
               state_in = status.end_flag ? ST_FLUSH : ST_FINISH;
            end else if (status.can_emit) begin
               cmd.shift_emit = 1'b1;
            end
         end
         ST_REPL: begin
            if (status.repl_done) begin
               state_in = ST_FINISH;
            end else if (status.can_emit) begin
               cmd.repl_emit = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (status.fill_zero) begin
               state_in = ST_FINISH;
            end else if (status.can_emit) begin
               cmd.shift_emit = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/stream_substring_replace_core.sv
// Top level of the streaming substring replace block.
// A request is accepted only while the controller is idle, so a new request is not taken
// until the previous request has finished. Released and replacement characters pass
// through a pending register into the output register, and output stalls hold the flow.
// Reset (synchronous, active high) clears the state machine, buffer fill, valids and config.
module stream_substring_replace_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ssr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ssr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [ssr_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ssr_pkg::WORD_BITS-1:0]     csr_wdata
);
   import ssr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence each request
   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold buffer, configuration and results
   ssr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (status)
   );

endmodule

### rtl/ssr_checker.sv
// Port-level checker for the streaming substring replace block, with its bind.
module ssr_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ssr_pkg::rsp_type  rsp_data
);
   import ssr_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // End of string closes the request's run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_end |-> rsp_data.run_last)
      else $error("string end without run last");

   // End-only marker carries no character and closes the string
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.char_valid |->
         rsp_data.string_end && (rsp_data.out_char == 8'd0))
      else $error("malformed end marker");

   // Drop any result on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stream_substring_replace_core ssr_checker u_ssr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/sv/stream_substring_replace_core_tb.sv
// Self-checking testbench for the streaming substring replace core.
module stream_substring_replace_core_tb;
   import ssr_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RAND_PHASES   = 6;
   localparam int PHASE_ITEMS   = 50;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_PATTERN_WORD;
   logic [WORD_BITS-1:0]    csr_wdata = '0;

   // Shadow copy of the configuration and the partial-match buffer
   logic [WORD_BITS-1:0] pat_word_q = '0;
   logic [WORD_BITS-1:0] rep_word_q = '0;
   len_type              pat_len_q  = '0;
   len_type              rep_len_q  = '0;
   char_type             match_q [MAX_PATTERN];
   int                   match_fill = 0;

   req_type pending_chars [$];
   rsp_type expected_chars [$];
   rsp_type step_results [$];
   rsp_type want;

   int       errors       = 0;
   int       sent         = 0;
   int       checked      = 0;
   int       phases       = 0;
   int       src_hold     = 0;
   int       sink_hold    = 0;
   int       quiet_cycles = 0;
   bit       calm         = 1'b0;
   logic     next_valid;
   char_type alpha_a, alpha_b;

   stream_substring_replace_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Character idx of a packed word; positions past the word read as zero
   function automatic char_type word_char(input logic [WORD_BITS-1:0] w, input int idx);
      if (idx * CHAR_BITS >= WORD_BITS) return '0;
      return w[idx*CHAR_BITS +: CHAR_BITS];
   endfunction

   function automatic void emit_char(input char_type ch, input logic valid);
      rsp_type r;
      r.out_char   = ch;
      r.char_valid = valid;
      r.run_last   = 1'b0;
      r.string_end = 1'b0;
      step_results.push_back(r);
   endfunction

   // Advance the shadow buffer by one request and queue the characters it releases
   function automatic void predict_replace(input req_type r);
      char_type work [MAX_PATTERN];
      int       plen, rlen, fill, n, start, len, i;
      bit       pref;
      step_results.delete();
      plen = (pat_len_q > MAX_PATTERN_LEN) ? MAX_PATTERN : int'(pat_len_q);
      rlen = (rep_len_q > MAX_REPLACE_LEN) ? MAX_REPLACE : int'(rep_len_q);
      if (plen == 0) begin
         emit_char(r.in_char, 1'b1);
         match_fill = 0;
      end else begin
         fill = (match_fill >= plen) ? plen - 1 : match_fill;
         for (i = 0; i < fill; i++) work[i] = match_q[i];
         work[fill] = r.in_char;
         n = fill + 1;
         start = 0;
         // Release characters that can no longer begin an occurrence
         while (start < n) begin
            len = n - start;
            pref = 1'b1;
            for (i = 0; i < len; i++) begin
               if (work[start+i] !== word_char(pat_word_q, i)) begin
                  pref = 1'b0;
                  break;
               end
            end
            if (pref) begin
               if (len == plen) begin
                  for (i = 0; i < rlen; i++) emit_char(word_char(rep_word_q, i), 1'b1);
                  start = n;
               end
               break;
            end
            emit_char(work[start], 1'b1);
            start++;
         end
         if (r.in_end) begin
            for (i = start; i < n; i++) emit_char(work[i], 1'b1);
         end else begin
            for (i = start; i < n; i++) match_q[i-start] = work[i];
            match_fill = n - start;
         end
      end
      if (r.in_end) begin
         match_fill = 0;
         if (step_results.size() == 0) emit_char('0, 1'b0);
      end
      if (step_results.size() != 0) begin
         step_results[step_results.size()-1].run_last   = 1'b1;
         step_results[step_results.size()-1].string_end = r.in_end;
      end
      foreach (step_results[k]) expected_chars.push_back(step_results[k]);
   endfunction

   // Driver: present queued requests with a random gap after each accept
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_hold = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            predict_replace(req_data);
            sent++;
            next_valid = 1'b0;
            src_hold = calm ? 0 : $urandom_range(0, 7);
         end
         if (!next_valid) begin
            if (src_hold > 0) begin
               src_hold--;
            end else if (pending_chars.size() != 0) begin
               req_data <= pending_chars.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Monitor: check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected result char=%h valid=%b last=%b end=%b", $realtime,
                        rsp_data.out_char, rsp_data.char_valid, rsp_data.run_last,
                        rsp_data.string_end);
            end else begin
               want = expected_chars.pop_front();
               checked++;
               if (rsp_data.out_char !== want.out_char ||
                   rsp_data.char_valid !== want.char_valid ||
                   rsp_data.run_last !== want.run_last ||
                   rsp_data.string_end !== want.string_end) begin
                  errors++;
                  $display("%0t: mismatch expected char=%h valid=%b last=%b end=%b",
                           $realtime, want.out_char, want.char_valid, want.run_last,
                           want.string_end);
                  $display("%0t:          actual   char=%h valid=%b last=%b end=%b",
                           $realtime, rsp_data.out_char, rsp_data.char_valid,
                           rsp_data.run_last, rsp_data.string_end);
               end
            end
            sink_hold = calm ? 0 : $urandom_range(0, 7);
         end else if (sink_hold > 0) begin
            sink_hold--;
         end
         rsp_ready <= (sink_hold == 0);
      end
   end

   // Watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $realtime, quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_req(input char_type ch, input bit last);
      req_type r;
      r.in_char = ch;
      r.in_end  = last;
      pending_chars.push_back(r);
   endtask

   // Write one register and mirror it in the shadow copy; only called while idle
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [WORD_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PATTERN_WORD: begin
            pat_word_q = value;
            match_fill = 0;
         end
         CSR_PATTERN_LEN: begin
            pat_len_q = value[LEN_BITS-1:0];
            match_fill = 0;
         end
         CSR_REPLACE_WORD: rep_word_q = value;
         CSR_REPLACE_LEN:  rep_len_q = value[LEN_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold until every request is taken and every result is back, then let the core settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_valid || expected_chars.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      phases++;
   endtask

   // Draw a setting whose pattern comes from a two-letter alphabet
   task automatic random_config(input int ph);
      logic [WORD_BITS-1:0] pw;
      int                   pl, rl, sel, i;
      alpha_a = char_type'($urandom_range(0, 255));
      alpha_b = alpha_a ^ (char_type'(1) << $urandom_range(0, 7));
      sel = $urandom_range(0, 5);
      if (ph == 0) pl = 0;
      else if (sel == 0) pl = $urandom_range(9, 15);
      else pl = $urandom_range(1, 8);
      sel = $urandom_range(0, 5);
      if (sel == 0) rl = 0;
      else if (sel == 1) rl = $urandom_range(9, 15);
      else rl = $urandom_range(1, 8);
      pw = {$urandom, $urandom};
      for (i = 0; i < MAX_PATTERN && i < pl; i++)
         pw[i*CHAR_BITS +: CHAR_BITS] = $urandom_range(0, 1) ? alpha_a : alpha_b;
      write_reg(CSR_PATTERN_WORD, pw);
      write_reg(CSR_PATTERN_LEN, WORD_BITS'(pl));
      write_reg(CSR_REPLACE_WORD, {$urandom, $urandom});
      write_reg(CSR_REPLACE_LEN, WORD_BITS'(rl));
   endtask

   // Mostly alphabet text with whole pattern copies, plus some noise bytes
   task automatic random_text(input int count);
      int       k, i, plen;
      char_type ch;
      plen = (pat_len_q > MAX_PATTERN_LEN) ? MAX_PATTERN : int'(pat_len_q);
      k = 0;
      while (k < count) begin
         if (plen > 0 && $urandom_range(0, 3) == 0) begin
            for (i = 0; i < plen && k < count; i++) begin
               push_req(word_char(pat_word_q, i), (i == plen - 1) && ($urandom_range(0, 5) == 0));
               k++;
            end
         end else begin
            if ($urandom_range(0, 4) == 0) ch = char_type'($urandom_range(0, 255));
            else ch = $urandom_range(0, 1) ? alpha_a : alpha_b;
            push_req(ch, $urandom_range(0, 11) == 0);
            k++;
         end
      end
   endtask

   initial begin
      wait (reset == 1'b0);
      @(posedge clock);

      // Pass through with the reset setting, extreme characters
      push_req(8'h00, 1'b0);
      push_req(8'hFF, 1'b1);
      push_req(8'h55, 1'b0);
      push_req(8'hAA, 1'b1);
      wait_idle();

      // Pattern "ab" with junk above its length, replacement "XYZ"
      write_reg(CSR_PATTERN_WORD, 64'hFFFF_FFFF_FFFF_6261);
      write_reg(CSR_PATTERN_LEN, 64'd2);
      write_reg(CSR_REPLACE_WORD, 64'h0000_0000_005A_5958);
      write_reg(CSR_REPLACE_LEN, 64'd3);
      push_req("a", 1'b0);
      push_req("a", 1'b0);
      push_req("b", 1'b0);
      push_req("a", 1'b0);
      push_req("b", 1'b0);
      push_req("b", 1'b1);
      push_req("a", 1'b1);
      wait_idle();

      // Delete matches; a string that ends with nothing to emit, then a dangling prefix
      write_reg(CSR_REPLACE_LEN, 64'd0);
      push_req("a", 1'b0);
      push_req("b", 1'b1);
      push_req("x", 1'b0);
      push_req("a", 1'b0);
      wait_idle();

      // Rewrite the pattern mid-string; lengths beyond bound, all-ones pattern
      write_reg(CSR_PATTERN_WORD, '1);
      write_reg(CSR_PATTERN_LEN, 64'd15);
      write_reg(CSR_REPLACE_WORD, '0);
      write_reg(CSR_REPLACE_LEN, 64'd15);
      repeat (8) push_req(8'hFF, 1'b0);
      push_req(8'hFF, 1'b0);
      push_req(8'h00, 1'b1);
      wait_idle();

      // Random settings and text, some phases without idling
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         random_config(ph);
         calm = (ph % 3 == 1);
         random_text(PHASE_ITEMS);
         wait_idle();
      end

      $display("Run covered %0d requests over %0d setting phases, %0d results checked.",
               sent, phases, checked);
      $display("Errors found: %0d", errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### stream_substring_replace_core.f
rtl/ssr_pkg.sv
rtl/ssr_datapath.sv
rtl/ssr_ctrl.sv
rtl/stream_substring_replace_core.sv
rtl/ssr_checker.sv
tb/sv/stream_substring_replace_core_tb.sv
